@@ src/bgcd_pkg.sv @@
package bgcd_pkg;

    localparam int DATA_WIDTH = 31;
    localparam int SHIFT_W    = $clog2(DATA_WIDTH);
    localparam int COUNT_W    = 8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // stream payload widths, rounded up to whole bytes
    localparam int IN_DATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((DATA_WIDTH + COUNT_W + 7) / 8) * 8;

    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic done;
    } status_t;

endpackage

@@ src/bgcd_ctrl.sv @@
module bgcd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  bgcd_pkg::status_t status,
    output bgcd_pkg::cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd.load    = (state_reg == ST_IDLE) && in_valid;
        cmd.step    = (state_reg == ST_RUN) && !status.done;
        // result register must be free or draining this cycle
        cmd.capture = (state_reg == ST_RUN) && status.done && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_RUN)
        else $error("accepted transfer did not start a run");

    a_capture_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> out_valid)
        else $error("captured result not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && out_valid_reg && !out_ready))
        else $error("pending result overwritten");

endmodule

@@ src/bgcd_dp.sv @@
module bgcd_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bgcd_pkg::cmd_t                    cmd,
    input  logic [bgcd_pkg::DATA_WIDTH-1:0]   first_value,
    input  logic [bgcd_pkg::DATA_WIDTH-1:0]   second_value,
    output bgcd_pkg::status_t                 status,
    output logic [bgcd_pkg::DATA_WIDTH-1:0]   divisor,
    output logic [bgcd_pkg::COUNT_W-1:0]      step_count
);

    localparam int DW = bgcd_pkg::DATA_WIDTH;

    logic [DW-1:0]                n_reg, n_next;
    logic [DW-1:0]                m_reg, m_next;
    logic [bgcd_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic [bgcd_pkg::COUNT_W-1:0] steps_reg, steps_next;
    logic [DW-1:0]                divisor_reg;
    logic [bgcd_pkg::COUNT_W-1:0] step_count_reg;

    logic          n_even, m_even;
    logic [DW-1:0] n_half, m_half;
    logic [DW:0]   diff_mn;
    logic [DW-1:0] diff_nm;
    logic          swap;

    always_comb
    begin
        n_even  = !n_reg[0];
        m_even  = !m_reg[0];
        // halve each even operand; both even also bumps the common factor
        n_half  = n_even ? (n_reg >> 1) : n_reg;
        m_half  = m_even ? (m_reg >> 1) : m_reg;
        diff_mn = {1'b0, m_half} - {1'b0, n_half};
        diff_nm = n_half - m_half;
        swap    = diff_mn[DW];
    end

    always_comb
    begin
        n_next     = n_reg;
        m_next     = m_reg;
        shift_next = shift_reg;
        steps_next = steps_reg;
        priority if (cmd.load)
        begin
            if (first_value > second_value)
            begin
                n_next = second_value;
                m_next = first_value;
            end
            else
            begin
                n_next = first_value;
                m_next = second_value;
            end
            shift_next = '0;
            steps_next = '0;
        end
        else if (cmd.step)
        begin
            if (swap)
            begin
                n_next = m_half;
                m_next = diff_nm;
            end
            else
            begin
                n_next = n_half;
                m_next = diff_mn[DW-1:0];
            end
            if (n_even && m_even)
            begin
                shift_next = shift_reg + 1'b1;
            end
            if (steps_reg != bgcd_pkg::COUNT_MAX)
            begin
                steps_next = steps_reg + 1'b1;
            end
        end
        else
        begin
            n_next = n_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        m_reg     <= m_next;
        shift_reg <= shift_next;
        steps_reg <= steps_next;
        if (cmd.capture)
        begin
            divisor_reg    <= n_reg << shift_reg;
            step_count_reg <= steps_reg;
        end
    end

    assign status.done = (n_reg == '0) || (m_reg == '0);
    assign divisor     = divisor_reg;
    assign step_count  = step_count_reg;

    a_sum_drops: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> ({1'b0, n_reg} + {1'b0, m_reg}) < ($past({1'b0, n_reg}) + $past({1'b0, m_reg})))
        else $error("iteration did not shrink operands");

    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> n_reg <= m_reg)
        else $error("operand pair out of order");

    a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> shift_reg < bgcd_pkg::SHIFT_W'(DW))
        else $error("common factor exceeds operand width");

endmodule

@@ src/binary_gcd_with_step_count.sv @@
// channel   dir  handshake                    payload (low bit up)
// s_axis    in   s_tvalid / s_tready          s_tdata: first_value, second_value
// m_axis    out  m_tvalid / m_tready          m_tdata: divisor, step_count
//
// one item at a time: load, then one gcd iteration per cycle, then capture
// the iteration loop runs until either operand reaches zero
// the result register lets a new operand pair load while a result waits
// a run holds at the end until the result register is free
// reset clears the controller; operand and result registers are not reset
module binary_gcd_with_step_count (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bgcd_pkg::IN_DATA_W-1:0]    s_tdata,  // first_value, second_value, zero pad
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bgcd_pkg::OUT_DATA_W-1:0]   m_tdata   // divisor, step_count, zero pad
);

    localparam int DW = bgcd_pkg::DATA_WIDTH;
    localparam int CW = bgcd_pkg::COUNT_W;

    bgcd_pkg::cmd_t    cmd;
    bgcd_pkg::status_t status;
    logic [DW-1:0]     divisor;
    logic [CW-1:0]     step_count;

    bgcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    bgcd_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .first_value  (s_tdata[DW-1:0]),
        .second_value (s_tdata[2*DW-1:DW]),
        .status       (status),
        .divisor      (divisor),
        .step_count   (step_count)
    );

    assign m_tdata = {{(bgcd_pkg::OUT_DATA_W - DW - CW){1'b0}}, step_count, divisor};

endmodule
